[rtl/tws_pkg.sv]
// Shared types, constants and helpers of the thruster desaturation select block.
package tws_pkg;

  localparam int DATA_W   = 32;
  localparam int TIME_W   = 48;
  localparam int Q31_W    = 31;
  localparam int IDX_W    = 3;
  localparam int CMD_W    = 3;
  localparam int IN_TDATA_W  = 280;
  localparam int OUT_TDATA_W = 88;
  localparam int APB_AW   = 6;
  localparam int APB_DW   = 64;

  localparam int DEF_MAX_WHEELS    = 4;
  localparam int DEF_MAX_THRUSTERS = 8;
  localparam int DEF_FRAC_BITS     = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_AXIS  = 3'd0,
    CMD_THR   = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_SPEED = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_COOLDOWN = 3'd0,
    REG_THRESH   = 3'd1,
    REG_MAX_ON   = 3'd2,
    REG_NWHEEL   = 3'd3,
    REG_NTHR     = 3'd4
  } reg_idx_t;

  typedef enum logic {
    RD_SQRT = 1'b0,
    RD_DIV  = 1'b1
  } rd_op_t;

  typedef struct packed {
    logic   start;
    rd_op_t op;
  } rd_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (x > hi) return DATA_W'(hi);
    if (x < lo) return DATA_W'(lo);
    return DATA_W'(x);
  endfunction

endpackage

[rtl/thruster_wheel_desaturation_select.sv]
// Top level: stores, sequencer and result register of the thruster desaturation select block.
//
// Channel   Dir  Fields (low bit first)
// s_*       in   tuser: cmd; tdata: index, vec_x..z, dir_x..z, speed, call_time
// m_*       out  tuser: fired; tdata: thruster_index, on_time, total_on_time
// apb       in   cooldown_ns, momentum_threshold, max_on_time, wheel_count,
//                thruster_count at byte addresses 0, 8, 16, 24, 32
//
// Loads, speed updates and clears are taken in idle. A tick walks one shared
// 32x32 multiplier, one product at a time, and adds the torque norm, square
// root and divides when the dump direction is re-picked.
// Synchronous reset clears impulse, dump direction, last fire time, total
// and registers; the tables stay undefined until loaded.
// s_tready is high only in idle; a finished result waits in the output
// register, and a second result holds the block in S_FIN until the first is taken.
module thruster_wheel_desaturation_select #(
  parameter int MAX_WHEELS    = tws_pkg::DEF_MAX_WHEELS,
  parameter int MAX_THRUSTERS = tws_pkg::DEF_MAX_THRUSTERS,
  parameter int FRAC_BITS     = tws_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // index, vec_x, vec_y, vec_z, dir_x, dir_y, dir_z, speed, call_time
  input  logic [tws_pkg::IN_TDATA_W-1:0]      s_tdata,
  // cmd
  input  logic [tws_pkg::CMD_W-1:0]           s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // thruster_index, on_time, total_on_time
  output logic [tws_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // fired
  output logic                                m_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tws_pkg::APB_AW-1:0]          paddr,
  input  logic [tws_pkg::APB_DW-1:0]          pwdata,
  output logic [tws_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import tws_pkg::*;

  localparam int QW     = 64 - FRAC_BITS;
  localparam int ACC_W  = QW + 4;
  localparam int DVD_W  = DATA_W + FRAC_BITS;
  localparam int WI_W   = (MAX_WHEELS > 1) ? $clog2(MAX_WHEELS) : 1;
  localparam int TI_W   = (MAX_THRUSTERS > 1) ? $clog2(MAX_THRUSTERS) : 1;
  localparam int ENT_W  = $clog2(MAX_WHEELS + MAX_THRUSTERS + 1);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_MOM  = 14'b00000000000010,
    S_MSAT = 14'b00000000000100,
    S_MSQ  = 14'b00000000001000,
    S_MCHK = 14'b00000000010000,
    S_DDOT = 14'b00000000100000,
    S_DCHK = 14'b00000001000000,
    S_SEL  = 14'b00000010000000,
    S_SCMP = 14'b00000100000000,
    S_NSQ  = 14'b00001000000000,
    S_SQRT = 14'b00010000000000,
    S_DIV  = 14'b00100000000000,
    S_UPD  = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_t;

  // ---------------- input fields
  logic [IDX_W-1:0]         in_index;
  logic signed [DATA_W-1:0] in_vec [3];
  logic signed [DATA_W-1:0] in_dir [3];
  logic signed [DATA_W-1:0] in_speed;
  logic [TIME_W-1:0]        in_time;

  assign in_index  = s_tdata[2:0];
  assign in_vec[0] = s_tdata[34:3];
  assign in_vec[1] = s_tdata[66:35];
  assign in_vec[2] = s_tdata[98:67];
  assign in_dir[0] = s_tdata[130:99];
  assign in_dir[1] = s_tdata[162:131];
  assign in_dir[2] = s_tdata[194:163];
  assign in_speed  = s_tdata[226:195];
  assign in_time   = s_tdata[274:227];

  // ---------------- configuration registers
  logic [TIME_W-1:0] cooldown_ns;
  logic [Q31_W-1:0]  momentum_threshold;
  logic [Q31_W-1:0]  max_on_time;
  logic [2:0]        wheel_count;
  logic [3:0]        thruster_count;
  logic              cfg_wr;
  reg_idx_t          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_ns        <= '0;
      momentum_threshold <= '0;
      max_on_time        <= '0;
      wheel_count        <= '0;
      thruster_count     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_COOLDOWN: cooldown_ns        <= pwdata[TIME_W-1:0];
        REG_THRESH:   momentum_threshold <= pwdata[Q31_W-1:0];
        REG_MAX_ON:   max_on_time        <= pwdata[Q31_W-1:0];
        REG_NWHEEL:   wheel_count        <= pwdata[2:0];
        REG_NTHR:     thruster_count     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_COOLDOWN: prdata = APB_DW'(cooldown_ns);
      REG_THRESH:   prdata = APB_DW'(momentum_threshold);
      REG_MAX_ON:   prdata = APB_DW'(max_on_time);
      REG_NWHEEL:   prdata = APB_DW'(wheel_count);
      REG_NTHR:     prdata = APB_DW'(thruster_count);
      default:      prdata = '0;
    endcase
  end

  // counts limited to table sizes
  logic [ENT_W-1:0] nwh;
  logic [ENT_W-1:0] nthr;
  assign nwh  = (32'(wheel_count) > MAX_WHEELS) ? ENT_W'(MAX_WHEELS) : ENT_W'(wheel_count);
  assign nthr = (32'(thruster_count) > MAX_THRUSTERS) ? ENT_W'(MAX_THRUSTERS)
                                                       : ENT_W'(thruster_count);

  // ---------------- tables (undefined until loaded)
  logic signed [DATA_W-1:0] axes    [MAX_WHEELS][3];
  logic signed [DATA_W-1:0] speeds  [MAX_WHEELS];
  logic signed [DATA_W-1:0] torques [MAX_THRUSTERS][3];
  logic signed [DATA_W-1:0] dirs    [MAX_THRUSTERS][3];

  state_t state;
  logic   in_acc;
  cmd_t   in_cmd;
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_cmd   = cmd_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      unique case (in_cmd)
        CMD_AXIS: begin
          if (32'(in_index) < MAX_WHEELS) begin
            for (int c = 0; c < 3; c++) axes[WI_W'(in_index)][c] <= in_vec[c];
          end
        end
        CMD_THR: begin
          if (32'(in_index) < MAX_THRUSTERS) begin
            for (int c = 0; c < 3; c++) begin
              torques[TI_W'(in_index)][c] <= in_vec[c];
              dirs[TI_W'(in_index)][c]    <= in_dir[c];
            end
          end
        end
        CMD_SPEED: begin
          if (32'(in_index) < MAX_WHEELS) speeds[WI_W'(in_index)] <= in_speed;
        end
        default: ;
      endcase
    end
  end

  // ---------------- sequencer state
  logic                     ph;        // 0: issue product, 1: take product
  logic [2:0]               k;
  logic [ENT_W-1:0]         ent;
  logic                     pass2;
  logic [TIME_W-1:0]        now;
  logic signed [ACC_W-1:0]  sum [3];
  logic signed [DATA_W-1:0] m [3];
  logic [63:0]              ssq;
  logic [63:0]              thrsq;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc2;
  logic signed [ACC_W:0]    best;
  logic [TI_W-1:0]          sel;
  logic                     sel_ok;
  logic signed [ACC_W-1:0]  sel_fire;
  logic [Q31_W-1:0]         on;
  logic [DATA_W-1:0]        nroot;
  logic signed [DATA_W-1:0] imp  [3];
  logic signed [DATA_W-1:0] dump [3];
  logic [TIME_W-1:0]        last_fire;
  logic [TIME_W-1:0]        total;
  logic                     res_fired;

  // ---------------- shared multiplier
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [63:0]       prod_full;
  logic signed [QW-1:0]     prod_q;
  logic [1:0]               comp;
  logic [TI_W-1:0]          ti;
  logic [WI_W-1:0]          wi;

  assign comp = (k < 3'd3) ? k[1:0] : 2'(k - 3'd3);
  assign ti   = (state == S_SEL) ? ent[TI_W-1:0] : sel;
  assign wi   = ent[WI_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MOM: begin
        mul_a = speeds[wi];
        mul_b = axes[wi][comp];
      end
      S_MSQ: begin
        if (k == 3'd3) begin
          mul_a = $signed({1'b0, momentum_threshold});
          mul_b = $signed({1'b0, momentum_threshold});
        end else begin
          mul_a = m[comp];
          mul_b = m[comp];
        end
      end
      S_DDOT: begin
        mul_a = dump[comp];
        mul_b = m[comp];
      end
      S_SEL: begin
        if (k < 3'd3) begin
          mul_a = pass2 ? dump[comp] : m[comp];
          mul_b = torques[ti][comp];
        end else begin
          mul_a = imp[comp];
          mul_b = dirs[ti][comp];
        end
      end
      S_NSQ: begin
        mul_a = torques[ti][comp];
        mul_b = torques[ti][comp];
      end
      S_UPD: begin
        mul_a = $signed({1'b0, on});
        mul_b = dirs[ti][comp];
      end
      default: ;
    endcase
  end

  tws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk       (clk),
    .a         (mul_a),
    .b         (mul_b),
    .prod_full (prod_full),
    .prod_q    (prod_q)
  );

  // ---------------- square root / divide unit
  rd_req_t                  rd_req;
  rd_rsp_t                  rd_rsp;
  logic [63:0]              rd_opnd;
  logic [63:0]              rd_res;
  logic signed [DATA_W-1:0] tk;
  logic [DATA_W-1:0]        tk_mag;
  logic [DVD_W-1:0]         quo;
  logic signed [63:0]       quo_s;

  assign tk     = torques[sel][k[1:0]];
  assign tk_mag = tk[DATA_W-1] ? DATA_W'(-tk) : DATA_W'(tk);
  assign quo    = DVD_W'(rd_res);
  assign quo_s  = tk[DATA_W-1] ? -$signed(64'(quo)) : $signed(64'(quo));

  always_comb begin
    rd_req.start = 1'b0;
    rd_req.op    = RD_SQRT;
    rd_opnd      = ssq;
    if (state == S_SQRT && !ph) begin
      rd_req.start = 1'b1;
    end else if (state == S_DIV && !ph) begin
      rd_req.start = 1'b1;
      rd_req.op    = RD_DIV;
      rd_opnd      = 64'({tk_mag, {FRAC_BITS{1'b0}}}) << (64 - DVD_W);
    end
  end

  tws_rootdiv #(.DIV_STEPS(DVD_W)) u_rd (
    .clk     (clk),
    .rst     (rst),
    .req     (rd_req),
    .opnd    (rd_opnd),
    .divisor (nroot),
    .rsp     (rd_rsp),
    .result  (rd_res)
  );

  // ---------------- datapath helpers
  logic signed [ACC_W-1:0] pq_ext;
  logic signed [ACC_W:0]   margin;
  logic                    fire_pos;
  logic [TIME_W:0]         tot_sum;
  logic [TIME_W-1:0]       elapsed;

  assign pq_ext   = ACC_W'(prod_q);
  assign margin   = (ACC_W+1)'(acc) - (ACC_W+1)'(acc2);
  assign fire_pos = !acc[ACC_W-1] && (acc != '0);
  assign tot_sum  = {1'b0, total} + (TIME_W+1)'(on);
  assign elapsed  = in_time - last_fire;

  // ---------------- main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= 1'b0;
      m_tvalid  <= 1'b0;
      last_fire <= '0;
      total     <= '0;
      for (int c = 0; c < 3; c++) begin
        imp[c]  <= '0;
        dump[c] <= '0;
      end
    end else begin
      // S_FIN loads the next result itself
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_cmd == CMD_CLEAR) begin
              last_fire <= '0;
              total     <= '0;
              for (int c = 0; c < 3; c++) imp[c] <= '0;
            end else if (in_cmd == CMD_TICK && elapsed >= cooldown_ns) begin
              now   <= in_time;
              ent   <= '0;
              k     <= '0;
              ph    <= 1'b0;
              for (int c = 0; c < 3; c++) sum[c] <= '0;
              state <= S_MOM;
            end
          end
        end

        // momentum = -sum(speed * axis)
        S_MOM: begin
          if (ent == nwh) begin
            state <= S_MSAT;
          end else if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            sum[k[1:0]] <= sum[k[1:0]] + pq_ext;
            if (k == 3'd2) begin
              k   <= '0;
              ent <= ent + 1'b1;
            end else begin
              k <= k + 3'd1;
            end
          end
        end

        S_MSAT: begin
          for (int c = 0; c < 3; c++) m[c] <= sat32(-64'(sum[c]));
          ssq   <= '0;
          k     <= '0;
          state <= S_MSQ;
        end

        // three squares, then threshold squared
        S_MSQ: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (k == 3'd3) begin
              thrsq <= 64'(prod_full);
              state <= S_MCHK;
            end else begin
              ssq <= ssq + 64'(prod_full);
              k   <= k + 3'd1;
            end
          end
        end

        S_MCHK: begin
          if (ssq < thrsq) begin
            state <= S_IDLE;
          end else begin
            acc   <= '0;
            k     <= '0;
            state <= S_DDOT;
          end
        end

        S_DDOT: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph  <= 1'b0;
            acc <= acc + pq_ext;
            if (k == 3'd2) state <= S_DCHK;
            else k <= k + 3'd1;
          end
        end

        // aligned enough: keep the dump direction, go straight to the firing pick; else pick a new direction first
        S_DCHK: begin
          pass2  <= (acc > $signed(ACC_W'(momentum_threshold)));
          ent    <= '0;
          k      <= '0;
          acc    <= '0;
          acc2   <= '0;
          best   <= '0;
          sel_ok <= 1'b0;
          state  <= S_SEL;
        end

        // per thruster: fire = target . torque, match = impulse . dir
        S_SEL: begin
          if (ent == nthr) begin
            if (!pass2) begin
              if (sel_ok) begin
                ssq   <= '0;
                k     <= '0;
                state <= S_NSQ;
              end else begin
                pass2 <= 1'b1;
                ent   <= '0;
                best  <= '0;
                state <= S_SEL;
              end
            end else if (sel_ok) begin
              on    <= (sel_fire > $signed(ACC_W'(max_on_time))) ? max_on_time
                                                                 : Q31_W'(sel_fire);
              k     <= '0;
              state <= S_UPD;
            end else begin
              res_fired <= 1'b0;
              state     <= S_FIN;
            end
          end else if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (k < 3'd3) acc  <= acc + pq_ext;
            else          acc2 <= acc2 + pq_ext;
            if (k == 3'd5) state <= S_SCMP;
            else k <= k + 3'd1;
          end
        end

        S_SCMP: begin
          if (fire_pos && margin > best) begin
            sel      <= ent[TI_W-1:0];
            best     <= margin;
            sel_fire <= acc;
            sel_ok   <= 1'b1;
          end
          ent   <= ent + 1'b1;
          k     <= '0;
          acc   <= '0;
          acc2  <= '0;
          state <= S_SEL;
        end

        // new dump direction = torque / |torque|
        S_NSQ: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph  <= 1'b0;
            ssq <= ssq + 64'(prod_full);
            if (k == 3'd2) state <= S_SQRT;
            else k <= k + 3'd1;
          end
        end

        S_SQRT: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (rd_rsp.done) begin
            ph    <= 1'b0;
            nroot <= rd_res[DATA_W-1:0];
            k     <= '0;
            if (rd_res[DATA_W-1:0] == '0) begin
              for (int c = 0; c < 3; c++) dump[c] <= '0;
              pass2  <= 1'b1;
              ent    <= '0;
              best   <= '0;
              sel_ok <= 1'b0;
              state  <= S_SEL;
            end else begin
              state <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (rd_rsp.done) begin
            ph <= 1'b0;
            dump[k[1:0]] <= sat32(quo_s);
            if (k == 3'd2) begin
              k      <= '0;
              pass2  <= 1'b1;
              ent    <= '0;
              best   <= '0;
              sel_ok <= 1'b0;
              state  <= S_SEL;
            end else begin
              k <= k + 3'd1;
            end
          end
        end

        // impulse += on * dir, total and last fire time
        S_UPD: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            imp[k[1:0]] <= sat32(64'(imp[k[1:0]]) + 64'(prod_q));
            if (k == 3'd2) begin
              total     <= tot_sum[TIME_W] ? {TIME_W{1'b1}} : tot_sum[TIME_W-1:0];
              last_fire <= now;
              res_fired <= 1'b1;
              state     <= S_FIN;
            end else begin
              k <= k + 3'd1;
            end
          end
        end

        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_fired;
            m_tdata  <= {6'd0, total,
                         res_fired ? on : {Q31_W{1'b0}},
                         res_fired ? IDX_W'(sel) : {IDX_W{1'b0}}};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/tws_mul.sv]
// Shared signed 32x32 multiplier with registered product and floor-shifted Q result.
module tws_mul #(
  parameter int FRAC_BITS = tws_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic signed [tws_pkg::DATA_W-1:0] a,
  input  logic signed [tws_pkg::DATA_W-1:0] b,
  output logic signed [63:0]                prod_full,
  output logic signed [63-FRAC_BITS:0]      prod_q
);
  import tws_pkg::*;

  always_ff @(posedge clk) begin
    prod_full <= a * b;
  end

  // arithmetic shift = floor toward minus infinity
  assign prod_q = (64 - FRAC_BITS)'(prod_full >>> FRAC_BITS);

endmodule

[rtl/tws_rootdiv.sv]
// Iterative unit: integer square root (2 bits/step) or restoring divide (1 bit/step).
module tws_rootdiv #(
  parameter int DIV_STEPS = 32 + tws_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tws_pkg::rd_req_t            req,
  input  logic [63:0]                 opnd,
  input  logic [tws_pkg::DATA_W-1:0]  divisor,
  output tws_pkg::rd_rsp_t            rsp,
  output logic [63:0]                 result
);
  import tws_pkg::*;

  rd_op_t      op_q;
  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] x;
  logic [33:0] rem;
  logic [31:0] root;
  logic [31:0] dvs;

  logic [35:0] sq_sh;
  logic [35:0] sq_trial;
  logic [32:0] dv_sh;

  assign sq_sh    = {rem, x[63:62]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign dv_sh    = {rem[31:0], x[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == RD_SQRT) ? 6'd32 : 6'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_q <= req.op;
      x    <= opnd;
      rem  <= '0;
      root <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (op_q == RD_SQRT) begin
        x <= {x[61:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          rem  <= 34'(sq_sh - sq_trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= 34'(sq_sh);
          root <= {root[30:0], 1'b0};
        end
      end else begin
        if (dv_sh >= {1'b0, dvs}) begin
          rem <= 34'(dv_sh - {1'b0, dvs});
          x   <= {x[62:0], 1'b1};
        end else begin
          rem <= 34'(dv_sh);
          x   <= {x[62:0], 1'b0};
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result   = (op_q == RD_SQRT) ? 64'(root) : x;

endmodule

[rtl/tws_chk.sv]
// Port-level checker for the thruster desaturation select block, bound to the top level.
module tws_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tws_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            pready
);
  import tws_pkg::*;

  // after reset: idle, nothing pending
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no firing: index and on-time are zero
  a_nofire: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[33:0] == '0)
    else $error("non-zero command without firing");

  // a result is only presented while no request is being worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result raised while busy");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind thruster_wheel_desaturation_select tws_chk u_tws_chk (.*);

[test/testbench.sv]
// Testbench of the thruster desaturation select block: a predictor and a result stream checker.
`timescale 1ns / 1ps

module testbench;
  import tws_pkg::*;

  localparam int NWH = 4;
  localparam int NTH = 8;
  localparam int FB = 16;
  localparam longint MASK48 = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic         fired;
    logic [2:0]   thr;
    logic [30:0]  on_time;
    logic [47:0]  total;
  } firing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  thruster_wheel_desaturation_select uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor state: tables, accumulators and registers
  // ---------------------------------------------------------------------
  longint axis_tab[NWH][3];
  longint torque_tab[NTH][3];
  longint dir_tab[NTH][3];
  longint speed_tab[NWH];
  longint impulse[3];
  longint dump_dir[3];
  longint last_fire;
  longint total_on;
  longint r_cool, r_thresh, r_maxon, r_nwh, r_nth;

  // which entries have been written (recorded only; ticks do not consult them)
  bit axis_ok[NWH];
  bit thr_ok[NTH];
  bit speed_ok[NWH];

  firing_t firings_due[$];
  int errors = 0;
  bit hold_off = 1'b0;    // long receiver stall for the pressure test
  bit burst_rx = 1'b0;    // receiver never stalls
  int rx_wait = 0;        // cycles left in a random long receiver stall

  function automatic longint fshr(longint x);
    return x >>> FB;      // arithmetic shift floors
  endfunction

  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qdot(longint a[3], longint b[3]);
    return fshr(a[0] * b[0]) + fshr(a[1] * b[1]) + fshr(a[2] * b[2]);
  endfunction

  // sum of squares kept unsigned: three 2^62 terms fit in 64 bits
  function automatic logic [63:0] sq3(longint v[3]);
    logic [63:0] s;
    logic [63:0] m;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m = (v[k] < 0) ? -v[k] : v[k];
      s += m * m;
    end
    return s;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int best_thruster(longint tgt[3], int nth, output longint best);
    int sel;
    longint fire;
    longint margin;
    longint t[3];
    longint d[3];
    sel = -1;
    best = 0;
    for (int i = 0; i < nth; i++) begin
      for (int k = 0; k < 3; k++) begin
        t[k] = torque_tab[i][k];
        d[k] = dir_tab[i][k];
      end
      fire = qdot(tgt, t);
      margin = fire - qdot(impulse, d);
      if (margin > best && fire > 0) begin
        sel = i;
        best = margin;
      end
    end
    return sel;
  endfunction

  // One update tick; returns 1 when a result is produced.
  function automatic bit predict_tick(longint now, output firing_t f);
    longint sum[3];
    longint m[3];
    longint t[3];
    longint best;
    longint on;
    logic [63:0] n;
    int nwh;
    int nth;
    int sel;
    nwh = (r_nwh > NWH) ? NWH : int'(r_nwh);
    nth = (r_nth > NTH) ? NTH : int'(r_nth);
    f = '0;
    if (((now - last_fire) & MASK48) < r_cool) return 0;
    sum = '{0, 0, 0};
    for (int i = 0; i < nwh; i++)
      for (int k = 0; k < 3; k++)
        sum[k] += fshr(speed_tab[i] * axis_tab[i][k]);
    for (int k = 0; k < 3; k++) m[k] = sat(-sum[k]);
    if (sq3(m) < 64'(r_thresh) * 64'(r_thresh)) return 0;
    if (qdot(dump_dir, m) <= r_thresh) begin
      sel = best_thruster(m, nth, best);
      if (sel >= 0) begin
        for (int k = 0; k < 3; k++) t[k] = torque_tab[sel][k];
        n = int_sqrt(sq3(t));
        for (int k = 0; k < 3; k++)
          dump_dir[k] = (n == 0) ? 0 : sat((t[k] * 65536) / longint'(n));
      end
    end
    sel = best_thruster(dump_dir, nth, best);
    if (best > 0 && sel >= 0) begin
      for (int k = 0; k < 3; k++) t[k] = torque_tab[sel][k];
      on = qdot(dump_dir, t);
      if (on > r_maxon) on = r_maxon;
      last_fire = now;
      total_on += on;
      if (total_on > MASK48) total_on = MASK48;
      for (int k = 0; k < 3; k++)
        impulse[k] = sat(impulse[k] + fshr(on * dir_tab[sel][k]));
      f.fired = 1'b1;
      f.thr = sel[2:0];
      f.on_time = on[30:0];
    end
    f.total = total_on[47:0];
    return 1;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------
  // valid stays high after a request until the next one or a gap replaces it
  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    s_tvalid <= 1'b0;
    if (r < 93) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(10, 60)) @(negedge clk);
  endtask

  task automatic send_request(cmd_t c, logic [2:0] idx, longint v[3], longint d[3],
                              longint spd, longint t, bit gaps = 1);
    firing_t f;
    if (gaps) idle_gap();
    s_tuser <= c;
    s_tdata <= {t[47:0], spd[31:0], d[2][31:0], d[1][31:0], d[0][31:0],
                v[2][31:0], v[1][31:0], v[0][31:0], idx};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (c)
      CMD_AXIS: if (idx < NWH) begin
        for (int k = 0; k < 3; k++) axis_tab[idx][k] = longint'(signed'(v[k][31:0]));
        axis_ok[idx] = 1;
      end
      CMD_THR: if (idx < NTH) begin
        for (int k = 0; k < 3; k++) begin
          torque_tab[idx][k] = longint'(signed'(v[k][31:0]));
          dir_tab[idx][k] = longint'(signed'(d[k][31:0]));
        end
        thr_ok[idx] = 1;
      end
      CMD_CLEAR: begin
        impulse = '{0, 0, 0};
        last_fire = 0;
        total_on = 0;
      end
      CMD_SPEED: if (idx < NWH) begin
        speed_tab[idx] = longint'(signed'(spd[31:0]));
        speed_ok[idx] = 1;
      end
      CMD_TICK: if (predict_tick(t & MASK48, f)) firings_due.push_back(f);
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic longint rnd32();
    return longint'(signed'($urandom()));
  endfunction

  // mostly modest Q16.16 values so that products stay meaningful
  function automatic longint rnd_q();
    case ($urandom_range(0, 9))
      0: return rnd32();
      1: return 0;
      default: return longint'($urandom_range(0, 196608)) - 98304;
    endcase
  endfunction

  function automatic longint rnd_time();
    return {$urandom(), $urandom()} & MASK48;
  endfunction

  task automatic send_random(cmd_t c, logic [2:0] idx);
    longint v[3];
    longint d[3];
    for (int k = 0; k < 3; k++) begin
      v[k] = rnd_q();
      d[k] = rnd_q();
    end
    send_request(c, idx, v, d, rnd_q(), rnd_time());
  endtask

  task automatic tick_at(longint t);
    longint z[3];
    z = '{0, 0, 0};
    send_request(CMD_TICK, 3'd0, z, z, 0, t);
  endtask

  // ---------------------------------------------------------------------
  // Configuration writes over APB (registers at 8*i, idle block only)
  // ---------------------------------------------------------------------
  task automatic write_reg(reg_idx_t r, longint val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= APB_AW'(8 * int'(r));
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_COOLDOWN: r_cool = val & MASK48;
      REG_THRESH:   r_thresh = val & 64'h7FFF_FFFF;
      REG_MAX_ON:   r_maxon = val & 64'h7FFF_FFFF;
      REG_NWHEEL:   r_nwh = val & 7;
      REG_NTHR:     r_nth = val & 15;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (firings_due.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    // a tick with no result may still be running
    repeat (1000) @(posedge clk);
  endtask

  task automatic configure(longint cool, longint thr, longint mx, longint nw, longint nt);
    drain();
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_THRESH, thr);
    write_reg(REG_MAX_ON, mx);
    write_reg(REG_NWHEEL, nw);
    write_reg(REG_NTHR, nt);
  endtask

  // load every entry so no tick ever touches an unwritten one
  task automatic load_all();
    for (int i = 0; i < NWH; i++) begin
      send_random(CMD_AXIS, 3'(i));
      send_random(CMD_SPEED, 3'(i));
    end
    for (int i = 0; i < NTH; i++) send_random(CMD_THR, 3'(i));
  endtask

  // ---------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    firing_t got;
    firing_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[2:0], m_tdata[33:3], m_tdata[81:34]};
      if (firings_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = firings_due.pop_front();
        if (got.fired !== want.fired) begin
          $display("%0t: fired exp %0d got %0d", $time, want.fired, got.fired);
          errors++;
        end
        if (got.thr !== want.thr) begin
          $display("%0t: thruster exp %0d got %0d", $time, want.thr, got.thr);
          errors++;
        end
        if (got.on_time !== want.on_time) begin
          $display("%0t: on_time exp %h got %h", $time, want.on_time, got.on_time);
          errors++;
        end
        if (got.total !== want.total) begin
          $display("%0t: total exp %h got %h", $time, want.total, got.total);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 999);
    if (rst || hold_off) m_tready <= 1'b0;
    else if (burst_rx) m_tready <= 1'b1;
    else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else if (r < 5) begin
      rx_wait = $urandom_range(10, 60);
      m_tready <= 1'b0;
    end else m_tready <= (r >= 300);
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  longint zv[3] = '{0, 0, 0};

  // Field extremes, every command, unknown commands, out-of-range indexes.
  task automatic test_directed();
    longint v[3];
    longint d[3];
    configure(0, 0, 64'h7FFF_FFFF, 4, 8);
    v = '{64'sd2147483647, -64'sd2147483648, 0};
    d = '{-64'sd2147483648, 64'sd2147483647, -1};
    for (int i = 0; i < NWH; i++) send_request(CMD_AXIS, 3'(i), v, d, 0, 0);
    for (int i = 0; i < NWH; i++) send_request(CMD_SPEED, 3'(i), v, d, 64'sd65536, 0);
    for (int i = 0; i < NTH; i++) send_request(CMD_THR, 3'(i), d, v, 0, MASK48);
    // index beyond wheel table and unknown commands: ignored
    send_request(CMD_AXIS, 3'd7, v, v, -64'sd2147483648, MASK48);
    send_request(CMD_SPEED, 3'd5, v, v, 64'sd2147483647, MASK48);
    send_request(cmd_t'(3'd5), 3'd7, v, d, -1, MASK48);
    send_request(cmd_t'(3'd7), 3'd0, v, d, -1, MASK48);
    tick_at(0);
    tick_at(MASK48);
    send_request(CMD_CLEAR, 3'd0, zv, zv, 0, 0);
    tick_at(5);
    // all-zero speeds: momentum zero, threshold zero, no match
    for (int i = 0; i < NWH; i++) send_request(CMD_SPEED, 3'(i), zv, zv, 0, 0);
    tick_at(100);
  endtask

  // Cooldown, threshold, clamp and count settings including extremes.
  task automatic test_settings();
    configure(1000, 64'h7FFF_FFFF, 0, 7, 15);   // counts limited, huge threshold
    load_all();
    repeat (10) tick_at(rnd_time());
    configure(MASK48, 0, 64'h7FFF_FFFF, 4, 8);  // cooldown wraps modulo 2^48
    send_request(CMD_CLEAR, 3'd0, zv, zv, 0, 0);
    repeat (10) tick_at(rnd_time());
    configure(500, 65536, 32768, 0, 0);         // no wheels, no thrusters
    repeat (5) tick_at(rnd_time());
    configure(200, 20000, 40000, 2, 3);
    for (int n = 0; n < 30; n++) tick_at(longint'(n) * 150);
  endtask

  // Block fills up while the receiver holds off for a long stretch.
  task automatic test_backpressure();
    configure(0, 0, 64'h7FFF_FFFF, 4, 8);
    hold_off = 1'b1;
    fork
      begin
        for (int n = 0; n < 20; n++) begin
          send_random(CMD_SPEED, 3'($urandom_range(0, 3)));
          tick_at(rnd_time());
        end
        s_tvalid <= 1'b0;
      end
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  // Mostly well-formed sequences: reloads, speed updates, ticks, clears.
  task automatic test_random();
    int sent;
    int r;
    sent = 0;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: configure(0, 0, 64'h7FFF_FFFF, 4, 8);
        1: configure($urandom_range(0, 3000), $urandom_range(0, 65536),
                     $urandom_range(1, 200000), $urandom_range(1, 4), $urandom_range(1, 8));
        2: configure(0, $urandom_range(0, 20000), 64'h7FFF_FFFF, 4, 8);
        3: configure(rnd_time(), rnd32() & 64'h7FFF_FFFF, rnd32() & 64'h7FFF_FFFF, 4, 8);
        default: configure(10, 1000, 100000, 3, 5);
      endcase
      burst_rx = (phase == 2);
      while (sent < (phase + 1) * 300) begin
        r = $urandom_range(0, 99);
        if (r < 40) tick_at($urandom_range(0, 3) == 0 ? rnd_time()
                            : longint'(sent) * 1000);
        else if (r < 70) send_random(CMD_SPEED, 3'($urandom_range(0, 7)));
        else if (r < 80) send_random(CMD_THR, 3'($urandom_range(0, 7)));
        else if (r < 88) send_random(CMD_AXIS, 3'($urandom_range(0, 7)));
        else if (r < 92) send_request(CMD_CLEAR, 3'($urandom()), zv, zv, rnd32(), rnd_time());
        else send_random(cmd_t'(3'($urandom_range(5, 7))), 3'($urandom()));
        sent++;
      end
    end
    burst_rx = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NWH; i++) speed_tab[i] = 0;
    impulse = '{0, 0, 0};
    dump_dir = '{0, 0, 0};
    last_fire = 0;
    total_on = 0;
    r_cool = 0; r_thresh = 0; r_maxon = 0; r_nwh = 0; r_nth = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_settings();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && firings_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
